>>> rtl/toi_pkg.sv
package toi_pkg;

  // CORDIC
  localparam int CORDIC_ITERATIONS = 16;
  localparam int CORDIC_TABLE_LEN  = 24;
  localparam int CW                = 34;
  localparam int CNT_W             = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
  localparam logic signed [CW-1:0] CORDIC_K_Q30 = 34'sd652032874;

  // divider
  localparam int DIV_NW = 58;
  localparam int DIV_DW = 31;
  localparam int DIV_CW = $clog2(DIV_NW);

  // scale constants
  localparam logic signed [63:0] BAM_SCALE_Q40 = 64'sd751587969;
  localparam logic signed [31:0] GYRO_URAD     = 32'sd1064;

  // steer to binary angle: 2^32 = 119304 * 36000 + 23296
  localparam logic [16:0] STEER_QUO = 17'd119304;
  localparam logic [14:0] STEER_REM = 15'd23296;
  localparam logic [14:0] STEER_RND = 15'd18000;
  // ceil(2^36 / 1125), exact for dividends below 2^25
  localparam logic [26:0] STEER_REC = 27'd61083980;

  // position step: divide by 1000 * 2^20, 2^18 = 262 * 1000 + 144
  localparam logic [63:0] POS_RND     = 64'd524288000;
  localparam logic [8:0]  POS_BLK_QUO = 9'd262;
  localparam logic [7:0]  POS_BLK_REM = 8'd144;
  // ceil(2^36 / 1000), exact for dividends below 2^26
  localparam logic [26:0] POS_REC     = 27'd68719477;

  // register map
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] REG_WHEEL_BASE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_ODOM_GAIN  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_USE_GYRO   = 2'd2;

  typedef struct packed {
    logic signed [15:0] wheel_speed_mm_s;
    logic signed [15:0] steer_centideg;
    logic signed [15:0] gyro_yaw_raw;
    logic        [19:0] elapsed_us;
  } in_t;

  typedef struct packed {
    logic signed [39:0] pos_x_um;
    logic signed [39:0] pos_y_um;
    logic signed [31:0] heading_bam;
    logic signed [15:0] forward_speed_mm_s;
    logic signed [31:0] yaw_rate_urad_s;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_STEER, S_STEER_REC, S_STEER_BAM, S_C1, S_C1_W, S_FWD_MUL, S_FWD,
    S_T_MUL, S_T_DIV, S_T_DIV_W, S_GAIN_MUL, S_YAW, S_YDT_MUL,
    S_HI_MUL, S_LO_MUL, S_DTH, S_C2, S_C2_W, S_DIST,
    S_X_MUL, S_X_DIV, S_X_REC, S_X_ACC, S_Y_MUL, S_Y_DIV, S_Y_REC, S_Y_ACC, S_DONE
  } state_t;

  function automatic logic signed [CW-1:0] atan_bam(input logic [4:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/toi_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module toi_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [toi_pkg::DIV_NW-1:0]  num,
  input  logic [toi_pkg::DIV_DW-1:0]  den,
  output logic                        done,
  output logic [toi_pkg::DIV_NW-1:0]  quo
);
  import toi_pkg::*;

  logic              run;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   trial;

  assign shifted = {rem, quo[DIV_NW-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dsr <= den;
    end else if (run) begin
      if (!trial[DIV_DW]) begin
        rem <= trial[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/toi_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle.
module toi_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [31:0]                    angle,
  output logic                           done,
  output logic signed [toi_pkg::CW-1:0]  cos_q30,
  output logic signed [toi_pkg::CW-1:0]  sin_q30
);
  import toi_pkg::*;

  logic             run;
  logic             flip;
  logic [CNT_W-1:0] cnt;
  logic signed [CW-1:0] x, y, z;
  logic signed [CW-1:0] dx, dy, at;
  logic             flip_in;
  logic [31:0]      a_adj;

  assign flip_in = angle[31] ^ angle[30];   // quadrants 2 and 3
  assign a_adj   = angle ^ {flip_in, 31'b0};
  assign dx      = y >>> cnt;
  assign dy      = x >>> cnt;
  assign at      = atan_bam(5'(cnt));
  assign cos_q30 = flip ? -x : x;
  assign sin_q30 = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CORDIC_ITERATIONS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip <= flip_in;
      x    <= CORDIC_K_Q30;
      y    <= '0;
      z    <= CW'($signed(a_adj));
    end else if (run) begin
      if (!z[CW-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

endmodule

>>> rtl/tricycle_odometry_integrator.sv
// Tricycle odometry integrator. Each input beat carries front-wheel speed,
// steering angle, a raw gyro yaw count and the elapsed time; one output beat
// returns the new pose (x, y in um, saturating; heading as a 32-bit binary
// angle) plus body forward speed and the selected yaw rate. A small sequencer
// walks each beat through one shared CORDIC unit (two passes: steering angle,
// then midpoint heading), one restoring divider (yaw over wheel base, wheel
// mode only) and a registered multiply per step; the divisions by constants
// (steer scaling, x and y steps) use a split plus a reciprocal multiply.
// The wait for out_valid is set mostly by the divider pass, taken in
// wheel-yaw mode only, and by the two CORDIC passes. in_ready is low from
// acceptance until the result has been handed over, so a new beat is taken
// only after that. Configuration writes are taken at any time but must only
// happen while idle.
module tricycle_odometry_integrator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  toi_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output toi_pkg::out_t               out_data,
  input  logic                        cfg_write,
  input  logic [toi_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [toi_pkg::CFG_DW-1:0]  cfg_wdata
);
  import toi_pkg::*;

  // config registers
  logic [15:0] wheel_base_mm;
  logic [15:0] odom_gain_q12;
  logic        use_gyro_yaw;

  // control
  state_t state, state_next;
  logic   div_start, cor_start;
  logic   div_done, cor_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;
  logic [31:0]       cor_angle;
  logic signed [CW-1:0] cor_cos, cor_sin;

  // datapath
  in_t cur;
  logic signed [63:0] acc, hm, lm;
  logic [31:0]        steer_bam;
  logic signed [CW-1:0] cq, sq, cm, sm;
  logic signed [15:0] fwd;
  logic signed [31:0] yaw;
  logic [32:0]        dth;
  logic [31:0]        heading;
  logic signed [39:0] x_acc, y_acc;
  logic               neg;
  logic [31:0]        q_base;
  logic [25:0]        q_num;
  logic [16:0]        q_hi;

  // combinational helpers
  logic [16:0]        st_mag;
  logic signed [63:0] fwd_s, t_rnd, yaw_rnd, dth_sum, quo_s;
  logic [63:0]        t_mag, hm_mag;
  logic [15:0]        base;
  logic [31:0]        mid;
  logic signed [CW-1:0] c20x, c20y;
  logic signed [40:0] x_sum, y_sum;
  logic [31:0]        st_prod, st_rem;
  logic [63:0]        pos_r;
  logic [31:0]        pos_qb;
  logic [25:0]        pos_qn;
  logic [26:0]        rec_k;
  logic [52:0]        rec_prod;
  logic [31:0]        q_sum;
  logic signed [40:0] pos_step;

  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] n,
                                                 input int s);
    logic signed [63:0] half;
    half = 64'sd1 <<< s;
    half = half >>> 1;
    if (!n[63]) return (n + half) >>> s;
    return -((-n + half) >>> s);
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    if (v[40] != v[39]) return v[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    return v[39:0];
  endfunction

  assign st_mag  = cur.steer_centideg[15] ? 17'(-$signed({cur.steer_centideg[15], cur.steer_centideg}))
                                          : 17'({1'b0, cur.steer_centideg});
  assign fwd_s   = (acc + 64'sd536870912) >>> 30;
  assign t_rnd   = rnd_shr(acc, 24);
  assign t_mag   = t_rnd[63] ? 64'(-t_rnd) : 64'(t_rnd);
  assign yaw_rnd = rnd_shr(acc, 12);
  assign dth_sum = hm + lm + 64'sd524288;
  assign hm_mag  = hm[63] ? 64'(-hm) : 64'(hm);
  assign base    = (wheel_base_mm == 16'd0) ? 16'd1 : wheel_base_mm;
  assign mid     = heading + dth[32:1];
  assign c20x    = (cm + CW'(512)) >>> 10;
  assign c20y    = (sm + CW'(512)) >>> 10;
  assign quo_s   = neg ? -64'(div_quo) : 64'(div_quo);

  // steer: |st| * 2^32 / 36000 = |st| * 119304 + (|st| * 23296 + 18000) / 36000
  assign st_prod = 32'(st_mag) * 32'(STEER_QUO);
  assign st_rem  = 32'(st_mag) * 32'(STEER_REM) + 32'(STEER_RND);

  // position: m = (|p| + half) >> 20 split as a * 2^18 + b, then m / 1000
  assign pos_r   = hm_mag + POS_RND;
  assign pos_qb  = 32'(pos_r[55:38]) * 32'(POS_BLK_QUO);
  assign pos_qn  = 26'(pos_r[55:38]) * 26'(POS_BLK_REM) + 26'(pos_r[37:20]);

  // shared reciprocal step, both constants scaled by 2^36
  assign rec_k    = (state == S_STEER_REC) ? STEER_REC : POS_REC;
  assign rec_prod = 53'(q_num) * 53'(rec_k);
  assign q_sum    = q_base + 32'(q_hi);
  assign pos_step = neg ? -$signed({9'b0, q_sum}) : $signed({9'b0, q_sum});
  assign x_sum    = 41'(x_acc) + pos_step;
  assign y_sum    = 41'(y_acc) + pos_step;

  assign in_ready = (state == S_IDLE) && !out_valid;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_base_mm <= 16'd300;
      odom_gain_q12 <= 16'd4096;
      use_gyro_yaw  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_WHEEL_BASE: wheel_base_mm <= cfg_wdata;
        REG_ODOM_GAIN:  odom_gain_q12 <= cfg_wdata;
        REG_USE_GYRO:   use_gyro_yaw  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    div_num    = '0;
    div_den    = DIV_DW'(base);
    cor_angle  = steer_bam;
    case (state)
      S_IDLE:      if (in_valid && in_ready) state_next = S_STEER;
      S_STEER:     state_next = S_STEER_REC;
      S_STEER_REC: state_next = S_STEER_BAM;
      S_STEER_BAM: state_next = S_C1;
      S_C1: begin
        cor_start  = 1'b1;
        state_next = S_C1_W;
      end
      S_C1_W:     if (cor_done) state_next = S_FWD_MUL;
      S_FWD_MUL:  state_next = S_FWD;
      S_FWD:      state_next = use_gyro_yaw ? S_YDT_MUL : S_T_MUL;
      S_T_MUL:    state_next = S_T_DIV;
      S_T_DIV: begin
        div_start  = 1'b1;
        div_num    = DIV_NW'(t_mag) + DIV_NW'(base >> 1);
        state_next = S_T_DIV_W;
      end
      S_T_DIV_W:  if (div_done) state_next = S_GAIN_MUL;
      S_GAIN_MUL: state_next = S_YAW;
      S_YAW:      state_next = S_YDT_MUL;
      S_YDT_MUL:  state_next = S_HI_MUL;
      S_HI_MUL:   state_next = S_LO_MUL;
      S_LO_MUL:   state_next = S_DTH;
      S_DTH:      state_next = S_C2;
      S_C2: begin
        cor_start  = 1'b1;
        cor_angle  = mid;
        state_next = S_C2_W;
      end
      S_C2_W:     if (cor_done) state_next = S_DIST;
      S_DIST:     state_next = S_X_MUL;
      S_X_MUL:    state_next = S_X_DIV;
      S_X_DIV:    state_next = S_X_REC;
      S_X_REC:    state_next = S_X_ACC;
      S_X_ACC:    state_next = S_Y_MUL;
      S_Y_MUL:    state_next = S_Y_DIV;
      S_Y_DIV:    state_next = S_Y_REC;
      S_Y_REC:    state_next = S_Y_ACC;
      S_Y_ACC:    state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc   <= '0;
      y_acc   <= '0;
      heading <= '0;
    end else begin
      case (state)
        S_C2:    heading <= heading + dth[31:0];
        S_X_ACC: x_acc <= sat40(x_sum);
        S_Y_ACC: y_acc <= sat40(y_sum);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE:    if (in_valid && in_ready) cur <= in_data;
      S_STEER: begin
        neg    <= cur.steer_centideg[15];
        q_base <= st_prod;
        q_num  <= st_rem[30:5];
      end
      S_STEER_REC: q_hi <= rec_prod[52:36];
      S_STEER_BAM: steer_bam <= neg ? -q_sum : q_sum;
      S_C1_W: if (cor_done) begin
        cq <= cor_cos;
        sq <= cor_sin;
      end
      S_FWD_MUL: acc <= 64'(cur.wheel_speed_mm_s) * 64'(cq);
      S_FWD: begin
        if (fwd_s > 64'sd32767)       fwd <= 16'sh7fff;
        else if (fwd_s < -64'sd32768) fwd <= 16'sh8000;
        else                          fwd <= fwd_s[15:0];
        yaw <= 32'(cur.gyro_yaw_raw) * GYRO_URAD;
        acc <= 64'(cur.wheel_speed_mm_s) * 64'(sq);
      end
      S_T_MUL:   acc <= acc * 64'sd15625;
      S_T_DIV:   neg <= t_rnd[63];
      S_T_DIV_W: if (div_done) acc <= quo_s;
      S_GAIN_MUL: acc <= acc * $signed({48'b0, odom_gain_q12});
      S_YAW: begin
        if (yaw_rnd > 64'sd2147483647)       yaw <= 32'sh7fffffff;
        else if (yaw_rnd < -64'sd2147483648) yaw <= 32'sh80000000;
        else                                 yaw <= yaw_rnd[31:0];
      end
      S_YDT_MUL: acc <= 64'(yaw) * $signed({44'b0, cur.elapsed_us});
      S_HI_MUL:  hm <= (acc >>> 20) * BAM_SCALE_Q40;
      S_LO_MUL:  lm <= ($signed({44'b0, acc[19:0]}) * BAM_SCALE_Q40) >>> 20;
      S_DTH:     dth <= dth_sum[52:20];
      S_C2_W: if (cor_done) begin
        cm <= cor_cos;
        sm <= cor_sin;
      end
      S_DIST:    acc <= 64'(fwd) * $signed({44'b0, cur.elapsed_us});
      S_X_MUL:   hm <= acc * 64'(c20x);
      S_X_DIV: begin
        neg    <= hm[63];
        q_base <= pos_qb;
        q_num  <= pos_qn;
      end
      S_X_REC:   q_hi <= rec_prod[52:36];
      S_Y_MUL:   hm <= acc * 64'(c20y);
      S_Y_DIV: begin
        neg    <= hm[63];
        q_base <= pos_qb;
        q_num  <= pos_qn;
      end
      S_Y_REC:   q_hi <= rec_prod[52:36];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      out_data.pos_x_um           <= x_acc;
      out_data.pos_y_um           <= y_acc;
      out_data.heading_bam        <= heading;
      out_data.forward_speed_mm_s <= fwd;
      out_data.yaw_rate_urad_s    <= yaw;
    end
  end

  toi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  toi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_q30 (cor_cos),
    .sin_q30 (cor_sin)
  );

endmodule

>>> rtl/toi_checker.sv
module toi_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped before acceptance");

  // one beat in flight: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("input taken while busy");

  // no new input while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready with result pending");

  // a result only follows a busy period
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

bind tricycle_odometry_integrator toi_checker u_toi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
